// ===== hdl/msl_pkg.sv =====
// Package for the masked signature locator: beat types, action and status codes.
// Used by all modules under hdl; depends on nothing.
package msl_pkg;

    localparam logic [1:0] ACT_LOAD = 2'd0;
    localparam logic [1:0] ACT_BYTE = 2'd1;
    localparam logic [1:0] ACT_END  = 2'd2;
    localparam logic [1:0] ACT_IDLE = 2'd3;

    localparam logic [2:0] ST_EXACT    = 3'd0;
    localparam logic [2:0] ST_JUMP     = 3'd1;
    localparam logic [2:0] ST_RELOC    = 3'd2;
    localparam logic [2:0] ST_NOTFOUND = 3'd3;

    localparam logic [1:0] REG_PREF   = 2'd0;
    localparam logic [1:0] REG_LEN    = 2'd1;
    localparam logic [1:0] REG_WINDOW = 2'd2;
    localparam logic [1:0] REG_NEAR   = 2'd3;

    localparam logic [7:0] JUMP_OPCODE = 8'hE9;

    typedef struct packed {
        logic [1:0] action;
        logic [5:0] entry_index;
        logic [7:0] pattern_byte;
        logic [7:0] mask_byte;
        logic [7:0] image_byte;
    } in_beat_t;

    typedef struct packed {
        logic [31:0] found_offset;
        logic [2:0]  status;
    } out_beat_t;

    // Classified item handed from the front to the back.
    typedef struct packed {
        logic        is_end;
        logic        hit;
        logic        at_pref;
        logic        jump;
        logic [31:0] start;
        logic        empty;
    } work_t;

    typedef struct packed {
        logic [31:0] pref;
        logic [31:0] window;
        logic [31:0] near;
        logic [6:0]  len;
    } cfg_t;

endpackage

// ===== hdl/msl_front.sv =====
// Front part: pattern store, byte history and a parallel masked compare.
// Depends on msl_pkg.
module msl_front #(
    parameter int MAX_PATTERN = 64
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  msl_pkg::in_beat_t in_beat,
    input  msl_pkg::cfg_t     cfg,
    output logic              wk_valid,
    input  logic              wk_ready,
    output msl_pkg::work_t    wk
);
    localparam int IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int LW = $clog2(MAX_PATTERN + 1);

    logic [7:0]  pat_reg  [MAX_PATTERN];
    logic [7:0]  msk_reg  [MAX_PATTERN];
    logic [7:0]  hist_reg [MAX_PATTERN];
    logic [31:0] count_reg;
    logic        wk_valid_reg;
    msl_pkg::work_t wk_reg, wk_next;
    logic [LW-1:0] len;
    logic [MAX_PATTERN-1:0] hist_ok;
    logic [MAX_PATTERN-1:0] lane_ok;
    logic        take;
    logic        byte_in;
    logic [7:0]  nh0;

    always_comb begin
        if (cfg.len == 7'd0) begin
            len = LW'(1);
        end else if ({25'd0, cfg.len} > 32'(MAX_PATTERN)) begin
            len = LW'(MAX_PATTERN);
        end else begin
            len = LW'(cfg.len);
        end
    end

    assign in_ready = !wk_valid_reg || wk_ready;
    assign take     = in_valid && in_ready;
    assign byte_in  = in_beat.action == msl_pkg::ACT_BYTE && count_reg != 32'hFFFF_FFFF;
    assign nh0      = in_beat.image_byte;

    // Lane k compares pattern byte k with the history byte that lands len-1-k back.
    always_comb begin
        for (int k = 0; k < MAX_PATTERN; k++) begin
            logic [7:0] hb;
            hb = 8'd0;
            for (int j = 0; j < MAX_PATTERN; j++) begin
                if (32'(j) == 32'(len) - 32'd1 - 32'(k)) begin
                    hb = (j == 0) ? nh0 : hist_reg[j-1];
                end
            end
            hist_ok[k] = (hb & msk_reg[k]) == (pat_reg[k] & msk_reg[k]);
            lane_ok[k] = hist_ok[k] || (32'(k) >= 32'(len));
        end
    end

    always_comb begin
        wk_next.is_end  = in_beat.action == msl_pkg::ACT_END;
        wk_next.empty   = count_reg == 32'd0;
        // On an end beat the start field carries the image size instead.
        wk_next.start   = (in_beat.action == msl_pkg::ACT_END) ? count_reg
                                                               : count_reg + 32'd1 - 32'(len);
        wk_next.hit     = byte_in && (count_reg + 32'd1 >= 32'(len)) && (&lane_ok);
        wk_next.at_pref = byte_in && count_reg == cfg.pref;
        wk_next.jump    = wk_next.at_pref && nh0 == msl_pkg::JUMP_OPCODE;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= 32'd0;
            wk_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_PATTERN; i++) hist_reg[i] <= 8'd0;
        end else begin
            wk_valid_reg <= take ? (wk_next.is_end || wk_next.hit || wk_next.at_pref)
                                 : (wk_valid_reg && !wk_ready);
            if (take) begin
                unique case (in_beat.action)
                    msl_pkg::ACT_LOAD: begin
                        if (32'(in_beat.entry_index) < 32'(MAX_PATTERN)) begin
                            pat_reg[IW'(in_beat.entry_index)] <= in_beat.pattern_byte;
                            msk_reg[IW'(in_beat.entry_index)] <= in_beat.mask_byte;
                        end
                    end
                    msl_pkg::ACT_BYTE: begin
                        if (byte_in) begin
                            hist_reg[0] <= nh0;
                            for (int i = 1; i < MAX_PATTERN; i++) hist_reg[i] <= hist_reg[i-1];
                            count_reg <= count_reg + 32'd1;
                        end
                    end
                    msl_pkg::ACT_END: begin
                        for (int i = 0; i < MAX_PATTERN; i++) hist_reg[i] <= 8'd0;
                        count_reg    <= 32'd0;
                    end
                    default: begin
                    end
                endcase
                wk_reg <= wk_next;
            end
        end
    end

    assign wk_valid = wk_valid_reg;
    assign wk       = wk_reg;
endmodule

// ===== hdl/msl_back.sv =====
// Back part: hit bookkeeping and the end-of-image decision with an output register.
// Depends on msl_pkg.
module msl_back #(
    parameter int MAX_PATTERN = 64,
    parameter int HIT_LIMIT   = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               wk_valid,
    output logic               wk_ready,
    input  msl_pkg::work_t     wk,
    input  msl_pkg::cfg_t      cfg,
    output logic               out_valid,
    input  logic               out_ready,
    output msl_pkg::out_beat_t out_beat
);
    localparam int HW = $clog2(HIT_LIMIT + 1);
    localparam int LW = $clog2(MAX_PATTERN + 1);

    logic [HW-1:0] wh_reg, fh_reg;
    logic [31:0] wfirst_reg, wbest_reg, wdist_reg;
    logic [31:0] ffirst_reg, fbest_reg, fdist_reg;
    logic        pm_reg, pj_reg;
    logic        ov_reg;
    msl_pkg::out_beat_t ob_reg;
    logic [31:0] lo, d;
    logic [32:0] hi;
    logic        in_win, take;
    logic [LW-1:0] len;
    logic [2:0]  st;
    logic [31:0] cand;
    logic        decided;

    always_comb begin
        if (cfg.len == 7'd0) len = LW'(1);
        else if ({25'd0, cfg.len} > 32'(MAX_PATTERN)) len = LW'(MAX_PATTERN);
        else len = LW'(cfg.len);
    end

    // Only an end beat needs the result register; hit records pass regardless.
    assign wk_ready = !wk.is_end || !ov_reg || out_ready;
    assign take     = wk_valid && wk_ready;
    assign lo       = (cfg.pref > cfg.window) ? cfg.pref - cfg.window : 32'd0;
    assign hi       = {1'b0, cfg.pref} + {1'b0, cfg.window};
    assign in_win   = cfg.pref != 32'd0 && wk.start >= lo && {1'b0, wk.start} <= hi;
    assign d        = (wk.start > cfg.pref) ? wk.start - cfg.pref : cfg.pref - wk.start;

    // End-of-image decision; wk.start holds the byte count on an end beat.
    always_comb begin
        st      = msl_pkg::ST_NOTFOUND;
        cand    = 32'd0;
        decided = 1'b0;
        if ({1'b0, cfg.pref} + 33'(len) <= {1'b0, wk.start}) begin
            if (pm_reg) begin
                st = msl_pkg::ST_EXACT; decided = 1'b1;
            end else if ({1'b0, cfg.pref} + 33'd5 <= {1'b0, wk.start} && pj_reg) begin
                st = msl_pkg::ST_JUMP; decided = 1'b1;
            end
        end
        if (!decided && cfg.pref != 32'd0) begin
            if (wh_reg == HW'(1)) begin
                cand = wfirst_reg; decided = 1'b1;
            end else if (wh_reg > HW'(1) && wdist_reg <= cfg.near) begin
                cand = wbest_reg; decided = 1'b1;
            end
        end
        if (!decided) begin
            if (fh_reg == HW'(1)) cand = ffirst_reg;
            else if (fh_reg > HW'(1) && cfg.pref != 32'd0 && fdist_reg <= cfg.near)
                cand = fbest_reg;
        end
        if (st == msl_pkg::ST_NOTFOUND && cand != 32'd0) st = msl_pkg::ST_RELOC;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (take && wk.is_end)) begin
            wh_reg <= '0; fh_reg <= '0;
            wfirst_reg <= '0; wbest_reg <= '0; wdist_reg <= '1;
            ffirst_reg <= '0; fbest_reg <= '0; fdist_reg <= '1;
            pm_reg <= 1'b0; pj_reg <= 1'b0;
        end else if (take) begin
            if (wk.jump) pj_reg <= 1'b1;
            if (wk.hit) begin
                if (wk.start == cfg.pref) pm_reg <= 1'b1;
                if (in_win && 32'(wh_reg) < 32'(HIT_LIMIT)) begin
                    if (wh_reg == '0) wfirst_reg <= wk.start;
                    if (d < wdist_reg) begin wdist_reg <= d; wbest_reg <= wk.start; end
                    wh_reg <= wh_reg + HW'(1);
                end
                if (32'(fh_reg) < 32'(HIT_LIMIT)) begin
                    if (fh_reg == '0) ffirst_reg <= wk.start;
                    if (d < fdist_reg) begin fdist_reg <= d; fbest_reg <= wk.start; end
                    fh_reg <= fh_reg + HW'(1);
                end
            end
        end
        if (!aresetn) begin
            ov_reg <= 1'b0;
        end else begin
            ov_reg <= (take && wk.is_end && !wk.empty) || (ov_reg && !out_ready);
            if (take && wk.is_end && !wk.empty) begin
                ob_reg.status       <= st;
                ob_reg.found_offset <= (st == msl_pkg::ST_RELOC) ? cand : cfg.pref;
            end
        end
    end

    assign out_valid = ov_reg;
    assign out_beat  = ob_reg;
endmodule

// ===== hdl/masked_signature_locator.sv =====
// Top level of the masked signature locator: config registers, front and back.
// Depends on msl_pkg, msl_front and msl_back.
//
// Load the pattern with load beats (byte and mask per position), stream the
// image one byte beat per cycle, then send an end beat; one result beat
// follows per non-empty image, with the chosen start offset and a status.
// The front compares the whole pattern against the byte history in parallel,
// and the back takes hit records without waiting on the output, so input
// ready stays high unless an end beat waits behind a result register that
// is full and unread. An end beat goes into the work register, then the result
// register. Configuration writes must be made only while the block is idle.
module masked_signature_locator #(
    parameter int MAX_PATTERN = 64,
    parameter int HIT_LIMIT   = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  msl_pkg::in_beat_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output msl_pkg::out_beat_t m_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data
);
    msl_pkg::cfg_t  cfg_reg;
    msl_pkg::work_t wk;
    logic           wk_valid, wk_ready;

    assign cfg_ready = 1'b1;

    // Register file; every index is one of the four registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pref   <= 32'd0;
            cfg_reg.len    <= 7'd1;
            cfg_reg.window <= 32'h0002_0000;
            cfg_reg.near   <= 32'h0001_0000;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                msl_pkg::REG_PREF:   cfg_reg.pref   <= cfg_data;
                msl_pkg::REG_LEN:    cfg_reg.len    <= cfg_data[6:0];
                msl_pkg::REG_WINDOW: cfg_reg.window <= cfg_data;
                msl_pkg::REG_NEAR:   cfg_reg.near   <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    msl_front #(.MAX_PATTERN(MAX_PATTERN)) u_front (
        .aclk, .aresetn,
        .in_valid(s_valid), .in_ready(s_ready), .in_beat(s_data),
        .cfg(cfg_reg), .wk_valid, .wk_ready, .wk
    );

    msl_back #(.MAX_PATTERN(MAX_PATTERN), .HIT_LIMIT(HIT_LIMIT)) u_back (
        .aclk, .aresetn, .wk_valid, .wk_ready, .wk, .cfg(cfg_reg),
        .out_valid(m_valid), .out_ready(m_ready), .out_beat(m_data)
    );
endmodule

// ===== hdl/msl_checker.sv =====
// Port-level checker for the masked signature locator, bound to the top level.
// Depends on msl_pkg.
module msl_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input msl_pkg::in_beat_t  s_data,
    input logic               m_valid,
    input logic               m_ready,
    input msl_pkg::out_beat_t m_data
);
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat dropped or changed while stalled");

    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.status <= msl_pkg::ST_NOTFOUND)
        else $error("bad status");

    // A fresh result always traces back to an accepted end beat, through the work register.
    a_end_to_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready && s_data.action == msl_pkg::ACT_END, 2))
        else $error("result without end beat");

    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");
endmodule

bind masked_signature_locator msl_checker u_msl_checker (.*);
